>>> src/sit_pkg.sv
// Shared types and constants for the segment intersection test pipeline.
// Depends on nothing; used by every module of the block.
`default_nettype none

package sit_pkg;

    localparam int unsigned LATENCY = 5;
    localparam logic [31:0] TOL_RESET = 32'd4295;

    typedef logic signed [31:0] coord_t;
    typedef logic signed [32:0] diff_t;
    typedef logic signed [65:0] prod_t;
    typedef logic signed [66:0] wide_t;

    typedef struct packed {
        diff_t rx;
        diff_t ry;
        diff_t sx;
        diff_t sy;
        diff_t qx;
        diff_t qy;
        diff_t wx;
        diff_t wy;
    } seg_diff_t;

    typedef struct packed {
        wide_t denom;
        wide_t tn;
        wide_t un;
        wide_t rr;
        wide_t d0;
        wide_t d1;
    } seg_sums_t;

endpackage

`default_nettype wire

>>> src/segment_intersection_test_top.sv
// A started beat gives hit with done via diff, product, sum, flag and hit registers.
// Throughput: one segment pair per cycle; busy is never raised and nothing stalls.
// The five stages are differences, products, sums, compares and the hit decision.
// Reset clears every valid bit and sets the parallel tolerance to 4295.
// Depends on sit_pkg, sit_diff, sit_mult and sit_cmp.
`default_nettype none

module segment_intersection_test_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic [31:0]  seg_a_start_x,
    input  wire logic [31:0]  seg_a_start_y,
    input  wire logic [31:0]  seg_a_end_x,
    input  wire logic [31:0]  seg_a_end_y,
    input  wire logic [31:0]  seg_b_start_x,
    input  wire logic [31:0]  seg_b_start_y,
    input  wire logic [31:0]  seg_b_end_x,
    input  wire logic [31:0]  seg_b_end_y,
    output logic              done,
    output logic              hit,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [31:0]  cfg_data
);

    logic [31:0]        tol_reg;
    logic [31:0]        tol_next;
    logic               accept;
    logic               diff_valid;
    sit_pkg::seg_diff_t diff;
    logic               sums_valid;
    sit_pkg::seg_sums_t sums;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign tol_next  = (cfg_valid && cfg_ready) ? cfg_data : tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= sit_pkg::TOL_RESET;
        end
        else
        begin
            tol_reg <= tol_next;
        end
    end

    sit_diff u_diff (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .ax1       (seg_a_start_x),
        .ay1       (seg_a_start_y),
        .ax2       (seg_a_end_x),
        .ay2       (seg_a_end_y),
        .bx1       (seg_b_start_x),
        .by1       (seg_b_start_y),
        .bx2       (seg_b_end_x),
        .by2       (seg_b_end_y),
        .out_valid (diff_valid),
        .diff      (diff)
    );

    sit_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (diff_valid),
        .diff      (diff),
        .out_valid (sums_valid),
        .sums      (sums)
    );

    sit_cmp u_cmp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sums_valid),
        .sums      (sums),
        .tol       (tol_reg),
        .out_valid (done),
        .hit       (hit)
    );

`ifndef SYNTHESIS
    // Every result beat traces back to a beat accepted a fixed latency earlier.
    a_done_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, sit_pkg::LATENCY))
        else $error("result beat without a matching accepted beat");
`endif

endmodule

`default_nettype wire

>>> src/sit_diff.sv
// First pipeline stage: direction vectors of both segments and offsets of both endpoints
// of the second segment from the start of the first. Depends on sit_pkg.
`default_nettype none

module sit_diff (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire sit_pkg::coord_t   ax1,
    input  wire sit_pkg::coord_t   ay1,
    input  wire sit_pkg::coord_t   ax2,
    input  wire sit_pkg::coord_t   ay2,
    input  wire sit_pkg::coord_t   bx1,
    input  wire sit_pkg::coord_t   by1,
    input  wire sit_pkg::coord_t   bx2,
    input  wire sit_pkg::coord_t   by2,
    output logic                   out_valid,
    output sit_pkg::seg_diff_t     diff
);

    logic                valid_reg;
    sit_pkg::seg_diff_t  diff_reg;
    sit_pkg::seg_diff_t  diff_next;

    function automatic sit_pkg::diff_t sub33(sit_pkg::coord_t a, sit_pkg::coord_t b);
        sit_pkg::diff_t ea;
        sit_pkg::diff_t eb;
        ea = {a[31], a};
        eb = {b[31], b};
        return ea - eb;
    endfunction

    always_comb
    begin
        diff_next.rx = sub33(ax2, ax1);
        diff_next.ry = sub33(ay2, ay1);
        diff_next.sx = sub33(bx2, bx1);
        diff_next.sy = sub33(by2, by1);
        diff_next.qx = sub33(bx1, ax1);
        diff_next.qy = sub33(by1, ay1);
        diff_next.wx = sub33(bx2, ax1);
        diff_next.wy = sub33(by2, ay1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
    end

    assign out_valid = valid_reg;
    assign diff      = diff_reg;

endmodule

`default_nettype wire

>>> src/sit_mult.sv
// Second and third pipeline stages: twelve registered products, then the cross
// and dot product sums. Depends on sit_pkg.
`default_nettype none

module sit_mult (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire sit_pkg::seg_diff_t  diff,
    output logic                     out_valid,
    output sit_pkg::seg_sums_t       sums
);

    typedef struct packed {
        sit_pkg::prod_t rx_sy;
        sit_pkg::prod_t ry_sx;
        sit_pkg::prod_t qx_sy;
        sit_pkg::prod_t qy_sx;
        sit_pkg::prod_t qx_ry;
        sit_pkg::prod_t qy_rx;
        sit_pkg::prod_t rx_rx;
        sit_pkg::prod_t ry_ry;
        sit_pkg::prod_t qx_rx;
        sit_pkg::prod_t qy_ry;
        sit_pkg::prod_t wx_rx;
        sit_pkg::prod_t wy_ry;
    } prod_set_t;

    logic               prod_valid_reg;
    prod_set_t          prod_reg;
    prod_set_t          prod_next;
    logic               sum_valid_reg;
    sit_pkg::seg_sums_t sums_reg;
    sit_pkg::seg_sums_t sums_next;

    function automatic sit_pkg::prod_t mul(sit_pkg::diff_t a, sit_pkg::diff_t b);
        sit_pkg::prod_t ea;
        sit_pkg::prod_t eb;
        ea = {{33{a[32]}}, a};
        eb = {{33{b[32]}}, b};
        return ea * eb;
    endfunction

    function automatic sit_pkg::wide_t ext(sit_pkg::prod_t a);
        return {a[65], a};
    endfunction

    always_comb
    begin
        prod_next.rx_sy = mul(diff.rx, diff.sy);
        prod_next.ry_sx = mul(diff.ry, diff.sx);
        prod_next.qx_sy = mul(diff.qx, diff.sy);
        prod_next.qy_sx = mul(diff.qy, diff.sx);
        prod_next.qx_ry = mul(diff.qx, diff.ry);
        prod_next.qy_rx = mul(diff.qy, diff.rx);
        prod_next.rx_rx = mul(diff.rx, diff.rx);
        prod_next.ry_ry = mul(diff.ry, diff.ry);
        prod_next.qx_rx = mul(diff.qx, diff.rx);
        prod_next.qy_ry = mul(diff.qy, diff.ry);
        prod_next.wx_rx = mul(diff.wx, diff.rx);
        prod_next.wy_ry = mul(diff.wy, diff.ry);
    end

    always_comb
    begin
        sums_next.denom = ext(prod_reg.rx_sy) - ext(prod_reg.ry_sx);
        sums_next.tn    = ext(prod_reg.qx_sy) - ext(prod_reg.qy_sx);
        sums_next.un    = ext(prod_reg.qx_ry) - ext(prod_reg.qy_rx);
        sums_next.rr    = ext(prod_reg.rx_rx) + ext(prod_reg.ry_ry);
        sums_next.d0    = ext(prod_reg.qx_rx) + ext(prod_reg.qy_ry);
        sums_next.d1    = ext(prod_reg.wx_rx) + ext(prod_reg.wy_ry);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            sum_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sums_reg <= sums_next;
    end

    assign out_valid = sum_valid_reg;
    assign sums      = sums_reg;

`ifndef SYNTHESIS
    // A squared length can never come out negative.
    a_rr_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid_reg |-> !sums_reg.rr[66])
        else $error("squared length of the first segment is negative");
`endif

endmodule

`default_nettype wire

>>> src/sit_cmp.sv
// Fourth and fifth pipeline stages: signed compares against zero, the tolerance,
// the denominator and the squared length, then the hit decision. Depends on sit_pkg.
`default_nettype none

module sit_cmp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire sit_pkg::seg_sums_t  sums,
    input  wire logic [31:0]         tol,
    output logic                     out_valid,
    output logic                     hit
);

    typedef struct packed {
        logic den_zero;
        logic den_lt_tol;
        logic den_gt_ntol;
        logic den_neg;
        logic un_zero;
        logic un_lt_tol;
        logic un_gt_ntol;
        logic tn_ge0;
        logic tn_le0;
        logic tn_le_den;
        logic tn_ge_den;
        logic un_ge0;
        logic un_le0;
        logic un_le_den;
        logic un_ge_den;
        logic rr_zero;
        logic d0_le_d1;
        logic d0_ge0;
        logic d1_ge0;
        logic d0_le_rr;
        logic d1_le_rr;
    } flags_t;

    logic           flag_valid_reg;
    flags_t         flags_reg;
    flags_t         flags_next;
    logic           done_reg;
    logic           hit_reg;
    logic           hit_next;
    sit_pkg::wide_t pos_tol;
    sit_pkg::wide_t neg_tol;
    sit_pkg::wide_t den;
    sit_pkg::wide_t tn;
    sit_pkg::wide_t un;
    sit_pkg::wide_t rr;
    sit_pkg::wide_t d0;
    sit_pkg::wide_t d1;
    logic           parallel;
    logic           collinear;
    logic           lo_le_rr;
    logic           hi_ge0;
    logic           cross_hit;
    logic           span_hit;

    always_comb
    begin
        pos_tol = {35'd0, tol};
        neg_tol = -pos_tol;
        den     = sums.denom;
        tn      = sums.tn;
        un      = sums.un;
        rr      = sums.rr;
        d0      = sums.d0;
        d1      = sums.d1;

        flags_next.den_zero    = (den == '0);
        flags_next.den_lt_tol  = (den < pos_tol);
        flags_next.den_gt_ntol = (den > neg_tol);
        flags_next.den_neg     = den[66];
        flags_next.un_zero     = (un == '0);
        flags_next.un_lt_tol   = (un < pos_tol);
        flags_next.un_gt_ntol  = (un > neg_tol);
        flags_next.tn_ge0      = !tn[66];
        flags_next.tn_le0      = tn[66] || (tn == '0);
        flags_next.tn_le_den   = (tn <= den);
        flags_next.tn_ge_den   = (tn >= den);
        flags_next.un_ge0      = !un[66];
        flags_next.un_le0      = un[66] || (un == '0);
        flags_next.un_le_den   = (un <= den);
        flags_next.un_ge_den   = (un >= den);
        flags_next.rr_zero     = (rr == '0);
        flags_next.d0_le_d1    = (d0 <= d1);
        flags_next.d0_ge0      = !d0[66];
        flags_next.d1_ge0      = !d1[66];
        flags_next.d0_le_rr    = (d0 <= rr);
        flags_next.d1_le_rr    = (d1 <= rr);
    end

    always_comb
    begin
        parallel  = flags_reg.den_zero
                  || (flags_reg.den_lt_tol && flags_reg.den_gt_ntol);
        collinear = flags_reg.un_zero
                  || (flags_reg.un_lt_tol && flags_reg.un_gt_ntol);
        lo_le_rr  = flags_reg.d0_le_d1 ? flags_reg.d0_le_rr : flags_reg.d1_le_rr;
        hi_ge0    = flags_reg.d0_le_d1 ? flags_reg.d1_ge0 : flags_reg.d0_ge0;
        span_hit  = collinear && !flags_reg.rr_zero && lo_le_rr && hi_ge0;
        if (flags_reg.den_neg)
        begin
            cross_hit = flags_reg.tn_le0 && flags_reg.tn_ge_den
                      && flags_reg.un_le0 && flags_reg.un_ge_den;
        end
        else
        begin
            cross_hit = flags_reg.tn_ge0 && flags_reg.tn_le_den
                      && flags_reg.un_ge0 && flags_reg.un_le_den;
        end
        hit_next = flag_valid_reg && (parallel ? span_hit : cross_hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            flag_valid_reg <= in_valid;
            done_reg       <= flag_valid_reg;
            hit_reg        <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flags_reg <= flags_next;
    end

    assign out_valid = done_reg;
    assign hit       = hit_reg;

`ifndef SYNTHESIS
    // The hit flag is only ever raised together with its strobe.
    a_hit_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> done_reg)
        else $error("hit raised without a result beat");
`endif

endmodule

`default_nettype wire
